// ===== rtl/sequence_gap_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// sequence_gap_monitor assertion macros
// shared property forms for the gap monitor checks
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_GAP_MONITOR_ASSERT_SVH
`define SEQUENCE_GAP_MONITOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SGM_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("sequence_gap_monitor: same-cycle check failed");

// condition holds in the cycle after the trigger
`define SGM_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("sequence_gap_monitor: next-cycle check failed");

`endif

// ===== rtl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// sizes, constants and the counter entry type of the sequence gap monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  // table size and counter width
  localparam int MAX_TALKERS = 8;
  localparam int COUNT_WIDTH = 32;

  // fixed field widths
  localparam int MAC_W = 48;
  localparam int SEQ_W = 16;
  localparam int OUT_W = 32;
  localparam int IDX_W = 3;

  // derived widths
  localparam int SLOT_W = (MAX_TALKERS > 1) ? $clog2(MAX_TALKERS) : 1;
  localparam int CNT_W  = $clog2(MAX_TALKERS + 1);
  localparam int SUM_W  = ((COUNT_WIDTH > SEQ_W) ? COUNT_WIDTH : SEQ_W) + 1;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // one word of the counter memory
  typedef struct packed {
    logic [SEQ_W-1:0]       last_seq;
    logic [COUNT_WIDTH-1:0] frames;
    logic [COUNT_WIDTH-1:0] gaps;
    logic [COUNT_WIDTH-1:0] missing;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/sequence_gap_monitor.sv =====
// ----------------------------------------------------------------------------
// sequence_gap_monitor
// per-talker frame counter gap detector with a dump of the talker table
// ----------------------------------------------------------------------------
// known talker frame: accept, address lookup, counter read-modify-write, then
//   ready again; new or dropped talker: accept and address lookup only; no result
// dump of n talkers: busy in the dump state, n results, one per cycle, each
//   registered after its dump read; an empty table gives one result on the next cycle
// unqualified frame: busy stays low; the receiver cannot stall
// reset (rst, synchronous): clears talker count, sequencer and strobe only
`timescale 1ns / 1ps
`default_nettype none

module sequence_gap_monitor (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      cmd,
  input  wire logic                      frame_ok,
  input  wire logic [sgm_pkg::MAC_W-1:0] src_mac,
  input  wire logic [sgm_pkg::SEQ_W-1:0] seq_count,
  output logic                           valid,
  output logic [sgm_pkg::IDX_W-1:0]      talker_index,
  output logic [sgm_pkg::MAC_W-1:0]      talker_mac,
  output logic [sgm_pkg::OUT_W-1:0]      frame_total,
  output logic [sgm_pkg::OUT_W-1:0]      gap_total,
  output logic [sgm_pkg::OUT_W-1:0]      missing_total,
  output logic                           no_talker,
  output logic                           last
);

  import sgm_pkg::*;

  `include "sequence_gap_monitor_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DUMP
  } state_t;

  state_t state;

  // talker count and address table (compared in parallel)
  logic [CNT_W-1:0]  talker_count;
  logic [MAC_W-1:0]  addr_tab [MAX_TALKERS];

  // latched frame fields
  logic [MAC_W-1:0]  mac_r;
  logic [SEQ_W-1:0]  seq_r;

  // slot under update and dump read pointer
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] rd_idx;

  // counter memory
  entry_t            mem [MAX_TALKERS];
  logic [SLOT_W-1:0] mem_rd_addr;
  entry_t            rd_data;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wr_addr;
  entry_t            mem_wr_data;

  // pending result
  logic              pend_valid;
  logic [SLOT_W-1:0] pend_idx;
  logic              pend_none;
  logic              pend_last;

  // address lookup
  logic              found;
  logic [SLOT_W-1:0] match_slot;
  logic              table_full;

  // counter update
  logic [SEQ_W-1:0]       step;
  logic [SEQ_W-1:0]       miss_add;
  logic                   is_gap;
  logic [SUM_W-1:0]       miss_sum;
  logic [COUNT_WIDTH-1:0] frames_next;
  logic [COUNT_WIDTH-1:0] gaps_next;
  logic [COUNT_WIDTH-1:0] missing_next;
  entry_t                 new_entry;

  assign busy       = (state != ST_IDLE);
  assign table_full = (talker_count == CNT_W'(MAX_TALKERS));

  // match against all allocated slots
  always_comb begin
    found      = 1'b0;
    match_slot = '0;
    for (int i = 0; i < MAX_TALKERS; i++) begin
      if ((CNT_W'(i) < talker_count) && (addr_tab[i] == mac_r)) begin
        found      = 1'b1;
        match_slot = SLOT_W'(i);
      end
    end
  end

  // saturating counter arithmetic on the entry read back
  always_comb begin
    step      = seq_r - rd_data.last_seq;
    is_gap    = (step != SEQ_W'(1));
    miss_add  = step - SEQ_W'(1);
    miss_sum  = SUM_W'(rd_data.missing) + SUM_W'(miss_add);
    frames_next = (rd_data.frames == CNT_MAX) ? rd_data.frames
                                              : rd_data.frames + COUNT_WIDTH'(1);
    if (!is_gap) begin
      gaps_next    = rd_data.gaps;
      missing_next = rd_data.missing;
    end else begin
      gaps_next    = (rd_data.gaps == CNT_MAX) ? rd_data.gaps
                                               : rd_data.gaps + COUNT_WIDTH'(1);
      missing_next = (miss_sum > SUM_W'(CNT_MAX)) ? CNT_MAX
                                                  : miss_sum[COUNT_WIDTH-1:0];
    end
  end

  // fresh entry for a new talker
  always_comb begin
    new_entry.last_seq = seq_r;
    new_entry.frames   = COUNT_WIDTH'(1);
    new_entry.gaps     = '0;
    new_entry.missing  = '0;
  end

  // memory port control
  always_comb begin
    mem_rd_addr = (state == ST_DUMP) ? rd_idx : match_slot;
    mem_we      = 1'b0;
    mem_wr_addr = slot;
    mem_wr_data = new_entry;
    case (state)
      ST_LOOKUP: begin
        if (!found && !table_full) begin
          mem_we      = 1'b1;
          mem_wr_addr = talker_count[SLOT_W-1:0];
        end
      end
      ST_UPDATE: begin
        mem_we               = 1'b1;
        mem_wr_data.last_seq = seq_r;
        mem_wr_data.frames   = frames_next;
        mem_wr_data.gaps     = gaps_next;
        mem_wr_data.missing  = missing_next;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // counter memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    rd_data <= mem[mem_rd_addr];
  end

  // address table write on allocation
  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP && !found && !table_full) begin
      addr_tab[talker_count[SLOT_W-1:0]] <= mac_r;
    end
  end

  // sequencer and registered result controls
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      talker_count <= '0;
      pend_valid   <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            mac_r <= src_mac;
            seq_r <= seq_count;
            if (cmd) begin
              if (talker_count == '0) begin
                pend_valid <= 1'b1;
                pend_none  <= 1'b1;
                pend_last  <= 1'b1;
                pend_idx   <= '0;
              end else begin
                rd_idx <= '0;
                state  <= ST_DUMP;
              end
            end else if (frame_ok) begin
              state <= ST_LOOKUP;
            end
          end
        end
        ST_LOOKUP: begin
          slot <= match_slot;
          if (found) begin
            state <= ST_UPDATE;
          end else begin
            if (!table_full) begin
              talker_count <= talker_count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
        end
        ST_DUMP: begin
          pend_valid <= 1'b1;
          pend_none  <= 1'b0;
          pend_idx   <= rd_idx;
          pend_last  <= (CNT_W'(rd_idx) == talker_count - CNT_W'(1));
          if (CNT_W'(rd_idx) == talker_count - CNT_W'(1)) begin
            state <= ST_IDLE;
          end else begin
            rd_idx <= rd_idx + SLOT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign valid         = pend_valid;
  assign no_talker     = pend_none;
  assign last          = pend_last;
  assign talker_index  = pend_none ? '0 : IDX_W'(pend_idx);
  assign talker_mac    = pend_none ? '0 : addr_tab[pend_idx];
  assign frame_total   = pend_none ? '0 : OUT_W'(rd_data.frames);
  assign gap_total     = pend_none ? '0 : OUT_W'(rd_data.gaps);
  assign missing_total = pend_none ? '0 : OUT_W'(rd_data.missing);

  // checks
  `SGM_ASSERT_NOW(a_count_range, 1'b1, talker_count <= CNT_W'(MAX_TALKERS))
  `SGM_ASSERT_NOW(a_none_is_last, valid && no_talker, last)
  `SGM_ASSERT_NOW(a_none_when_empty, valid && no_talker, talker_count == '0)
  `SGM_ASSERT_NOW(a_update_slot_alloc, state == ST_UPDATE, CNT_W'(slot) < talker_count)
  `SGM_ASSERT_NEXT(a_unqualified_idle, start && !busy && !cmd && !frame_ok, !busy)

endmodule

`default_nettype wire
